### rtl/sfmt_pkg.sv
// ----------------------------------------------------------------------------
// sfmt_pkg
// shared types, constants and the recursion step of the sfmt19937 generator
// ----------------------------------------------------------------------------
package sfmt_pkg;

  localparam int unsigned LaneW      = 32;
  localparam int unsigned WordW      = 128;
  localparam int unsigned PickOffset = 122;
  localparam int unsigned LaneShl    = 18;
  localparam int unsigned LaneShr    = 11;

  localparam logic [LaneW-1:0] SeedMult  = 32'd1812433253;
  localparam logic [LaneW-1:0] LungValue = 32'h6d736d6d;
  localparam logic [WordW-1:0] LaneMask  =
    {32'hbffffff6, 32'hbffaffff, 32'hddfecb7f, 32'hdfffffef};

  typedef struct packed {
    logic              operation;
    logic [LaneW-1:0]  seed_value;
  } in_item_t;

  typedef struct packed {
    logic [LaneW-1:0]  random_word;
    logic              not_seeded;
  } out_item_t;

  // word write request from the seeding unit
  typedef struct packed {
    logic              wr;
    logic              last;
    logic [WordW-1:0]  word;
  } seed_wr_t;

  // one recursion step on 128-bit words
  function automatic logic [WordW-1:0] sfmt_recur(
    input logic [WordW-1:0] a,
    input logic [WordW-1:0] b,
    input logic [WordW-1:0] c,
    input logic [WordW-1:0] d
  );
    logic [WordW-1:0] lane_part;
    lane_part = '0;
    for (int k = 0; k < 4; k++) begin
      lane_part[k*LaneW +: LaneW] =
        ((b[k*LaneW +: LaneW] >> LaneShr) & LaneMask[k*LaneW +: LaneW]) ^
        (d[k*LaneW +: LaneW] << LaneShl);
    end
    return a ^ (a << 8) ^ (c >> 8) ^ lane_part;
  endfunction

endpackage

### rtl/sfmt_seed_gen.sv
// ----------------------------------------------------------------------------
// sfmt_seed_gen
// serial seed expansion, one 32-bit lane at a time, packed into words
// ----------------------------------------------------------------------------
module sfmt_seed_gen import sfmt_pkg::*; #(
  parameter int unsigned STATE_WORDS = 156
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LaneW-1:0] seed_i,
  output seed_wr_t         seed_wr_o
);

  localparam int unsigned Lanes = STATE_WORDS * 4;
  localparam int unsigned LaneIdxW = $clog2(Lanes);

  logic                busy_q;
  logic                mul_phase_q;
  logic [LaneIdxW-1:0] lane_q;
  logic [LaneW-1:0]    x_q;
  logic [LaneW-1:0]    mul_q;
  logic [3*LaneW-1:0]  buf_q;
  logic                emit;
  logic                last_lane;

  assign last_lane = (lane_q == LaneIdxW'(Lanes - 1));
  assign emit      = busy_q && !mul_phase_q && (lane_q[1:0] == 2'd3);

  always_comb begin
    seed_wr_o.wr   = emit;
    seed_wr_o.last = emit && last_lane;
    // word 0 gets the fixed top lane, the chain keeps the true value
    if (lane_q[LaneIdxW-1:2] == '0) begin
      seed_wr_o.word = {LungValue, buf_q};
    end else begin
      seed_wr_o.word = {x_q, buf_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mul_phase_q <= 1'b0;
      lane_q      <= '0;
    end else if (start_i) begin
      busy_q      <= 1'b1;
      mul_phase_q <= 1'b0;
      lane_q      <= '0;
    end else if (busy_q) begin
      if (mul_phase_q) begin
        mul_phase_q <= 1'b0;
        lane_q      <= lane_q + 1'b1;
      end else if (last_lane) begin
        busy_q <= 1'b0;
      end else begin
        mul_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= seed_i;
    end else if (busy_q) begin
      if (mul_phase_q) begin
        x_q <= mul_q + LaneW'(lane_q + 1'b1);
      end else begin
        mul_q <= SeedMult * (x_q ^ (x_q >> 30));
        if (lane_q[1:0] != 2'd3) begin
          buf_q[{lane_q[1:0], 5'd0} +: LaneW] <= x_q;
        end
      end
    end
  end

endmodule

### rtl/simd_mersenne_twister_19937.sv
// ----------------------------------------------------------------------------
// simd_mersenne_twister_19937
// sfmt19937 generator, 32-bit output, state held in a 128-bit wide memory
// ----------------------------------------------------------------------------
// a next transfer reads its word in StRead and loads it into the output slot in
//   StOut, or, before any seed, goes straight to StOut with not_seeded set;
//   when the store is used up it first regenerates all words
// a new request is taken only in idle, once the previous result is loaded into
//   the output slot; a regeneration pass runs once per 4*STATE_WORDS words
// a seed holds off the input while the seeding unit expands it one lane at a
//   time through the multiplier, and gives no result
// reset clears control state only; the state memory is not cleared and is
//   never read before a seed has written it
module simd_mersenne_twister_19937 import sfmt_pkg::*; #(
  parameter int unsigned STATE_WORDS = 156
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned Lanes = STATE_WORDS * 4;
  localparam int unsigned AddrW = $clog2(STATE_WORDS);
  localparam int unsigned RidxW = $clog2(Lanes + 1);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StSeed    = 3'd1;
  localparam logic [2:0] StRgPrime = 3'd2;
  localparam logic [2:0] StRgLoad  = 3'd3;
  localparam logic [2:0] StRgRun   = 3'd4;
  localparam logic [2:0] StRead    = 3'd5;
  localparam logic [2:0] StOut     = 3'd6;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(STATE_WORDS - 1);

  // state memory and its ports
  logic [WordW-1:0] mem [STATE_WORDS];
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [WordW-1:0] wdata;
  logic             re_a, re_b;
  logic [AddrW-1:0] raddr_a, raddr_b;
  logic [WordW-1:0] rdata_a_q, rdata_b_q;

  // control
  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] idx_q;       // word being written (seed and regen)
  logic [AddrW-1:0] jdx_q;       // word 122 ahead, wraps
  logic [AddrW-1:0] jdx_next;
  logic [RidxW-1:0] read_index_q;
  logic             seeded_q;
  logic             from_mem_q;  // pending result comes from the memory

  // the trailing two state words at the start of a pass, then its last two new words
  logic [WordW-1:0] r1_q, r2_q;
  logic [WordW-1:0] new_word;

  // output slot
  logic             out_valid_q;
  out_item_t        out_q;
  logic             out_load;

  // seeding unit
  logic             seed_start;
  seed_wr_t         seed_wr;

  logic             in_xfer;

  assign in_ready_o  = (state_q == StIdle);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign seed_start  = in_xfer && !in_data_i.operation;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == StOut) && (!out_valid_q || out_ready_i);

  sfmt_seed_gen #(
    .STATE_WORDS(STATE_WORDS)
  ) u_seed_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seed_start),
    .seed_i   (in_data_i.seed_value),
    .seed_wr_o(seed_wr)
  );

  assign jdx_next = (jdx_q == LastAddr) ? '0 : jdx_q + 1'b1;
  assign new_word = sfmt_recur(rdata_a_q, rdata_b_q, r1_q, r2_q);

  // memory port steering
  always_comb begin
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = new_word;
    unique case (state_q)
      StSeed: begin
        we    = seed_wr.wr;
        wdata = seed_wr.word;
      end
      StRgPrime: begin
        // current values of the two trailing words
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = AddrW'(STATE_WORDS - 2);
        raddr_b = LastAddr;
      end
      StRgLoad: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = '0;
        raddr_b = AddrW'(PickOffset);
      end
      StRgRun: begin
        we = 1'b1;
        // next pair; the b word is 122 ahead, or 34 behind and already rewritten once it wraps
        if (idx_q != LastAddr) begin
          re_a    = 1'b1;
          re_b    = 1'b1;
          raddr_a = idx_q + 1'b1;
          raddr_b = jdx_next;
        end
      end
      StRead: begin
        re_a    = 1'b1;
        raddr_a = read_index_q[AddrW+1:2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a_q <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_q <= mem[raddr_b];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          priority if (!in_data_i.operation) begin
            state_d = StSeed;
          end else if (!seeded_q) begin
            state_d = StOut;
          end else if (read_index_q == RidxW'(Lanes)) begin
            state_d = StRgPrime;
          end else begin
            state_d = StRead;
          end
        end
      end
      StSeed:    if (seed_wr.last) state_d = StIdle;
      StRgPrime: state_d = StRgLoad;
      StRgLoad:  state_d = StRgRun;
      StRgRun:   if (idx_q == LastAddr) state_d = StRead;
      StRead:    state_d = StOut;
      StOut:     if (out_load) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      jdx_q        <= '0;
      read_index_q <= RidxW'(Lanes);
      seeded_q     <= 1'b0;
      from_mem_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_xfer) begin
        idx_q      <= '0;
        from_mem_q <= in_data_i.operation && seeded_q;
      end

      unique case (state_q)
        StSeed: begin
          if (seed_wr.wr) begin
            idx_q <= idx_q + 1'b1;
          end
          if (seed_wr.last) begin
            seeded_q     <= 1'b1;
            read_index_q <= RidxW'(Lanes);
          end
        end
        StRgLoad: begin
          jdx_q <= AddrW'(PickOffset);
        end
        StRgRun: begin
          idx_q <= idx_q + 1'b1;
          jdx_q <= jdx_next;
          if (idx_q == LastAddr) begin
            read_index_q <= '0;
          end
        end
        StOut: begin
          if (out_load && from_mem_q) begin
            read_index_q <= read_index_q + 1'b1;
          end
        end
        default: ;
      endcase

      // output slot: a new result may load in the cycle the old one leaves
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StRgLoad) begin
      r1_q <= rdata_a_q;
      r2_q <= rdata_b_q;
    end else if (state_q == StRgRun) begin
      r1_q <= r2_q;
      r2_q <= new_word;
    end
    if (out_load) begin
      if (from_mem_q) begin
        out_q.random_word <= rdata_a_q[{read_index_q[1:0], 5'd0} +: LaneW];
        out_q.not_seeded  <= 1'b0;
      end else begin
        out_q.random_word <= '0;
        out_q.not_seeded  <= 1'b1;
      end
    end
  end

endmodule
